[rtl/packet_type_registry_defines.svh]
// assertion macros for the packet type registry
// expects clk and rst in scope at the point of use
`ifndef PACKET_TYPE_REGISTRY_DEFINES_SVH
`define PACKET_TYPE_REGISTRY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PTR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define PTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ptr_pkg.sv]
// shared types and constants for the packet type registry
// no dependencies
`default_nettype none

package ptr_pkg;

  localparam int unsigned PROBE_SLOTS_DEF = 256;
  localparam int unsigned IDENT_SLOTS_DEF = 64;

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned IDENT_W = 8;
  localparam int unsigned SIZE_W  = 8;
  localparam int unsigned STAT_W  = 3;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 8'd64;

  // action codes
  localparam logic ACT_DEFINE = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_IDENT_USED = 3'd1,
    ST_TOO_LARGE  = 3'd2,
    ST_DUPLICATE  = 3'd3,
    ST_NOT_FOUND  = 3'd4
  } status_t;

  // one identifier slot as held in memory
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [IDENT_W-1:0] ident;
    logic [SIZE_W-1:0]  size;
  } slot_entry_t;

  // one result transaction
  typedef struct packed {
    status_t            status;
    logic [IDENT_W-1:0] ident;
    logic [SIZE_W-1:0]  size;
  } result_t;

endpackage

`default_nettype wire

[rtl/ptr_if.sv]
// request and response channel interfaces for the packet type registry
// depends on ptr_pkg
`default_nettype none

interface ptr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ptr_pkg::KEY_W-1:0]   type_key;
  logic [ptr_pkg::IDENT_W-1:0] packet_ident;
  logic [ptr_pkg::SIZE_W-1:0]  payload_size;

  modport source (output valid, action, type_key, packet_ident, payload_size, input ready);
  modport sink   (input valid, action, type_key, packet_ident, payload_size, output ready);
endinterface

interface ptr_out_if;
  logic                         valid;
  logic                         ready;
  logic [ptr_pkg::STAT_W-1:0]   status;
  logic [ptr_pkg::IDENT_W-1:0]  found_ident;
  logic [ptr_pkg::SIZE_W-1:0]   found_size;

  modport source (output valid, status, found_ident, found_size, input ready);
  modport sink   (input valid, status, found_ident, found_size, output ready);
endinterface

`default_nettype wire

[rtl/ptr_vmem.sv]
// synchronous memory with per-entry valid flags, one read and one write port
// invalid entries read as zero; depends on nothing
`default_nettype none

module ptr_vmem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic                  rd_valid,
  output logic [WIDTH-1:0]      rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic             rd_vld_q;
  logic [WIDTH-1:0] rd_q;

  // valid flags, cleared at once by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // storage array and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // valid flag of the read entry, same latency as the data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en) begin
      rd_vld_q <= vld[rd_addr];
    end
  end

  assign rd_valid = rd_vld_q;
  assign rd_data  = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

[rtl/ptr_ctrl.sv]
// probe sequencer: identifier check, linear probe walk, result register
// depends on ptr_pkg and ptr_if; drives the link and slot memories
`default_nettype none

module ptr_ctrl #(
  parameter int unsigned PROBE_SLOTS = ptr_pkg::PROBE_SLOTS_DEF,
  parameter int unsigned IDENT_SLOTS = ptr_pkg::IDENT_SLOTS_DEF,
  localparam int unsigned PW         = $clog2(PROBE_SLOTS),
  localparam int unsigned SW         = $clog2(IDENT_SLOTS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  ptr_in_if.sink                          in_ch,
  ptr_out_if.source                       out_ch,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ptr_pkg::SIZE_W-1:0] cfg_wr_data,
  // link memory
  output logic                            link_rd_en,
  output logic [PW-1:0]                   link_rd_addr,
  input  wire logic                       link_rd_valid,
  input  wire logic [SW-1:0]              link_rd_data,
  output logic [PW-1:0]                   link_wr_addr,
  output logic [SW-1:0]                   link_wr_data,
  // slot memory
  output logic                            slot_rd_en,
  output logic [SW-1:0]                   slot_rd_addr,
  input  wire ptr_pkg::slot_entry_t       slot_rd_data,
  output logic [SW-1:0]                   slot_wr_addr,
  output ptr_pkg::slot_entry_t            slot_wr_data,
  // one write strobe for both memories
  output logic                            wr_en
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHK   = 5'b00010,
    S_LWAIT = 5'b00100,
    S_SCMP  = 5'b01000,
    S_PUT   = 5'b10000
  } state_t;

  state_t                       state, state_next;
  logic [PW-1:0]                pos, pos_next;
  logic [PW-1:0]                cnt, cnt_next;
  ptr_pkg::result_t             res, res_next;
  ptr_pkg::result_t             out_res;
  logic                         out_valid;
  logic [ptr_pkg::SIZE_W-1:0]   max_size;
  logic                         act_q;
  logic [ptr_pkg::KEY_W-1:0]    key_q;
  logic [ptr_pkg::IDENT_W-1:0]  ident_q;
  logic [ptr_pkg::SIZE_W-1:0]   size_q;
  logic                         in_acc;
  logic                         out_free;
  logic                         key_hit;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign key_hit     = (slot_rd_data.key == key_q);

  // writes of a define always target the current probe position and the item's slot
  assign link_wr_addr       = pos;
  assign link_wr_data       = ident_q[SW-1:0];
  assign slot_wr_addr       = ident_q[SW-1:0];
  assign slot_wr_data.key   = key_q;
  assign slot_wr_data.ident = ident_q;
  assign slot_wr_data.size  = size_q;

  // sequencer next state and memory requests
  always_comb begin
    state_next   = state;
    pos_next     = pos;
    cnt_next     = cnt;
    res_next     = res;
    link_rd_en   = 1'b0;
    link_rd_addr = pos;
    slot_rd_en   = 1'b0;
    slot_rd_addr = link_rd_data;
    wr_en        = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          pos_next = in_ch.type_key[PW-1:0];
          cnt_next = '0;
          res_next = '{status: ptr_pkg::ST_OK, ident: '0, size: '0};
          if (in_ch.action == ptr_pkg::ACT_DEFINE) begin
            slot_rd_en   = 1'b1;
            slot_rd_addr = in_ch.packet_ident[SW-1:0];
            state_next   = S_CHK;
          end else begin
            link_rd_en   = 1'b1;
            link_rd_addr = in_ch.type_key[PW-1:0];
            state_next   = S_LWAIT;
          end
        end
      end
      S_CHK: begin
        if (slot_rd_data.key != '0) begin
          res_next.status = ptr_pkg::ST_IDENT_USED;
          state_next      = S_PUT;
        end else if (size_q > max_size) begin
          res_next.status = ptr_pkg::ST_TOO_LARGE;
          state_next      = S_PUT;
        end else begin
          link_rd_en = 1'b1;
          state_next = S_LWAIT;
        end
      end
      S_LWAIT: begin
        if (!link_rd_valid) begin
          if (act_q == ptr_pkg::ACT_DEFINE) begin
            wr_en = 1'b1;
          end else begin
            res_next.status = ptr_pkg::ST_NOT_FOUND;
          end
          state_next = S_PUT;
        end else begin
          slot_rd_en = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        if (key_hit) begin
          if (act_q == ptr_pkg::ACT_DEFINE) begin
            res_next.status = ptr_pkg::ST_DUPLICATE;
          end else begin
            res_next.ident = slot_rd_data.ident;
            res_next.size  = slot_rd_data.size;
          end
          state_next = S_PUT;
        end else if (cnt == PW'(PROBE_SLOTS - 1)) begin
          // every position probed once
          res_next.status = ptr_pkg::ST_NOT_FOUND;
          state_next      = S_PUT;
        end else begin
          pos_next     = pos + PW'(1);
          cnt_next     = cnt + PW'(1);
          link_rd_en   = 1'b1;
          link_rd_addr = pos + PW'(1);
          state_next   = S_LWAIT;
        end
      end
      S_PUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      max_size  <= ptr_pkg::MAX_SIZE_RST;
    end else begin
      state <= state_next;
      if (state == S_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        max_size <= cfg_wr_data;
      end
    end
  end

  // item and result payload registers
  always_ff @(posedge clk) begin
    pos <= pos_next;
    cnt <= cnt_next;
    res <= res_next;
    if (in_acc) begin
      act_q   <= in_ch.action;
      key_q   <= in_ch.type_key;
      ident_q <= in_ch.packet_ident;
      size_q  <= in_ch.payload_size;
    end
    if (state == S_PUT && out_free) begin
      out_res <= res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = out_res.status;
  assign out_ch.found_ident = out_res.ident;
  assign out_ch.found_size  = out_res.size;

endmodule

`default_nettype wire

[rtl/packet_type_registry.sv]
// a define rejected on its identifier or size goes from the check straight to the result;
// otherwise each probe position visited takes a link read, and a slot read if the link is
// valid; a result still waiting adds its wait
// throughput: one transaction at a time; the next is accepted the cycle after the result loads
// reset: synchronous; valid flags of both memories clear at once, no clearing pass
// PROBE_SLOTS and IDENT_SLOTS must be powers of two
`default_nettype none
`include "packet_type_registry_defines.svh"

module packet_type_registry #(
  parameter int unsigned PROBE_SLOTS = ptr_pkg::PROBE_SLOTS_DEF,
  parameter int unsigned IDENT_SLOTS = ptr_pkg::IDENT_SLOTS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  ptr_in_if.sink                          in_ch,
  ptr_out_if.source                       out_ch,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ptr_pkg::SIZE_W-1:0] cfg_wr_data
);

  localparam int unsigned PW = $clog2(PROBE_SLOTS);
  localparam int unsigned SW = $clog2(IDENT_SLOTS);

  logic                 link_rd_en;
  logic [PW-1:0]        link_rd_addr;
  logic                 link_rd_valid;
  logic [SW-1:0]        link_rd_data;
  logic [PW-1:0]        link_wr_addr;
  logic [SW-1:0]        link_wr_data;
  logic                 slot_rd_en;
  logic [SW-1:0]        slot_rd_addr;
  logic                 slot_rd_valid;
  ptr_pkg::slot_entry_t slot_rd_data;
  logic [SW-1:0]        slot_wr_addr;
  ptr_pkg::slot_entry_t slot_wr_data;
  logic                 wr_en;

  // sequencer
  ptr_ctrl #(
    .PROBE_SLOTS (PROBE_SLOTS),
    .IDENT_SLOTS (IDENT_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .link_rd_en    (link_rd_en),
    .link_rd_addr  (link_rd_addr),
    .link_rd_valid (link_rd_valid),
    .link_rd_data  (link_rd_data),
    .link_wr_addr  (link_wr_addr),
    .link_wr_data  (link_wr_data),
    .slot_rd_en    (slot_rd_en),
    .slot_rd_addr  (slot_rd_addr),
    .slot_rd_data  (slot_rd_data),
    .slot_wr_addr  (slot_wr_addr),
    .slot_wr_data  (slot_wr_data),
    .wr_en         (wr_en)
  );

  // probe table: slot index per position
  ptr_vmem #(
    .DEPTH (PROBE_SLOTS),
    .WIDTH (SW)
  ) u_link_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (link_rd_en),
    .rd_addr  (link_rd_addr),
    .rd_valid (link_rd_valid),
    .rd_data  (link_rd_data),
    .wr_en    (wr_en),
    .wr_addr  (link_wr_addr),
    .wr_data  (link_wr_data)
  );

  // identifier slots: key, identifier, size
  ptr_vmem #(
    .DEPTH (IDENT_SLOTS),
    .WIDTH ($bits(ptr_pkg::slot_entry_t))
  ) u_slot_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (slot_rd_en),
    .rd_addr  (slot_rd_addr),
    .rd_valid (slot_rd_valid),
    .rd_data  (slot_rd_data),
    .wr_en    (wr_en),
    .wr_addr  (slot_wr_addr),
    .wr_data  (slot_wr_data)
  );

  // a define only claims a probe position that read back free
  `PTR_ASSERT_IMP(a_wr_free_pos, wr_en, !link_rd_valid, "define wrote over a used probe position")

  // a slot reached through a probe link has always been written
  `PTR_ASSERT_NXT(a_link_slot_written, slot_rd_en && !in_ch.ready, slot_rd_valid, "probe link names an unwritten slot")

  // only one transaction in flight
  `PTR_ASSERT_NXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted a second transaction while busy")

  // rejected or missed transactions carry no identifier or size
  `PTR_ASSERT_IMP(a_fail_fields_zero, out_ch.valid && out_ch.status != ptr_pkg::ST_OK, out_ch.found_ident == '0 && out_ch.found_size == '0, "failed result carries data")

endmodule

`default_nettype wire
